// ===== rtl/i2c_write_only_master_macros.svh =====
// Assertion macros shared by the write-only I2C master RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef I2C_WRITE_ONLY_MASTER_MACROS_SVH
`define I2C_WRITE_ONLY_MASTER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define I2CWO_ASSERT(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Property whose consequence must hold in the cycle after its condition.
`define I2CWO_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== rtl/i2cwo_pkg.sv =====
// Shared types and constants for the write-only I2C master.
// No dependencies; imported by the top, front end, back end and testbench.
`timescale 1ns / 1ps

package i2cwo_pkg;

    // Command codes on s_cmd.
    localparam logic [2:0] CMD_INIT  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_SEND  = 3'd2;
    localparam logic [2:0] CMD_STOP  = 3'd3;
    localparam logic [2:0] CMD_NOP   = 3'd4;

    // Default number of commands queued between front and back end.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_INIT,
        OP_START,
        OP_SEND,
        OP_STOP
    } op_kind_t;

    // One classified command as handed from the front end to the back end.
    typedef struct packed {
        op_kind_t    kind;
        logic        restart;
        logic [7:0]  byte_val;
    } job_t;

endpackage

// ===== rtl/i2c_write_only_master.sv =====
// Write-only I2C master: command channel in, stream of SCL/SDA line events out.
// The front end accepts a command beat on s_valid/s_ready and classifies it; a
// queue of QUEUE_DEPTH commands feeds the back end, which emits one line event
// per cycle while the receiver does not stall, on m_valid/m_ready into an output
// register. The first event of a command passes through the queue, the back-end
// state registers and the output register before it is valid. The back-end
// sequencer sets the events of init, stop, send byte and start (longer with a
// repeated start). No-op and unused codes are accepted and give no event.
// m_last_event marks the final event of each command. device_address is written
// through cfg_wr_en/cfg_wr_data and sampled when a start command is accepted.
// Reset clears the address to 0, marks the bus idle, empties the queue and drops
// m_valid. When the receiver stalls, the output register holds its event, the
// back end pauses, and s_ready falls once the queue is full.
// Depends on i2cwo_pkg, i2cwo_front, i2cwo_fifo and i2cwo_back.
`timescale 1ns / 1ps

module i2c_write_only_master
    import i2cwo_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_cmd,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_line_select,
    output logic       m_line_level,
    output logic       m_delay_after,
    output logic       m_last_event
);

    logic front_valid, front_ready;
    job_t front_job;
    logic back_valid, back_ready;
    job_t back_job;

    i2cwo_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_data_byte (s_data_byte),
        .job_valid   (front_valid),
        .job_ready   (front_ready),
        .job         (front_job)
    );

    i2cwo_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_job),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_job)
    );

    i2cwo_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (back_valid),
        .job_ready     (back_ready),
        .job           (back_job),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_line_select (m_line_select),
        .m_line_level  (m_line_level),
        .m_delay_after (m_delay_after),
        .m_last_event  (m_last_event)
    );

endmodule

// ===== rtl/i2cwo_fifo.sv =====
// Small register-based queue between the command front end and the event back end.
// Depends on the assertion macro header only.
`timescale 1ns / 1ps
`include "i2c_write_only_master_macros.svh"

module i2cwo_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop_fire) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push_fire && !pop_fire) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `I2CWO_ASSERT(a_fifo_count_range, aclk, aresetn, count_reg <= CNT_FULL, "queue count exceeds depth")
    `I2CWO_ASSERT_NEXT(a_fifo_push_grows, aclk, aresetn, push_fire && !pop_fire, count_reg == $past(count_reg) + CNT_W'(1), "queue count did not grow on push")
    `I2CWO_ASSERT_NEXT(a_fifo_pop_shrinks, aclk, aresetn, pop_fire && !push_fire, count_reg == $past(count_reg) - CNT_W'(1), "queue count did not drop on pop")

endmodule

// ===== rtl/i2cwo_front.sv =====
// Front end: holds the address register and bus state, classifies each command beat.
// Depends on i2cwo_pkg.
`timescale 1ns / 1ps

module i2cwo_front
    import i2cwo_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_cmd,
    input  logic [7:0] s_data_byte,
    output logic       job_valid,
    input  logic       job_ready,
    output job_t       job
);

    logic [6:0] device_address_reg;
    logic       bus_started_reg, bus_started_next;
    logic       has_events;
    logic       accept;

    assign s_ready = job_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        has_events       = 1'b1;
        job.kind         = OP_SEND;
        job.restart      = 1'b0;
        job.byte_val     = s_data_byte;
        bus_started_next = bus_started_reg;
        unique case (s_cmd)
            CMD_INIT: begin
                job.kind = OP_INIT;
            end
            CMD_START: begin
                job.kind         = OP_START;
                job.restart      = bus_started_reg;
                job.byte_val     = {device_address_reg, 1'b0};
                bus_started_next = 1'b1;
            end
            CMD_SEND: begin
                job.kind = OP_SEND;
            end
            CMD_STOP: begin
                job.kind         = OP_STOP;
                bus_started_next = 1'b0;
            end
            default: begin
                // No-op and unused codes are taken and dropped here.
                has_events = 1'b0;
            end
        endcase
    end

    assign job_valid = s_valid && has_events;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_address_reg <= '0;
            bus_started_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                device_address_reg <= cfg_wr_data;
            end
            if (accept) begin
                bus_started_reg <= bus_started_next;
            end
        end
    end

endmodule

// ===== rtl/i2cwo_back.sv =====
// Back end: steps through the line events of each queued command, one event per cycle while the output is free.
// Depends on i2cwo_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "i2c_write_only_master_macros.svh"

module i2cwo_back
    import i2cwo_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic job_valid,
    output logic job_ready,
    input  job_t job,
    output logic m_valid,
    input  logic m_ready,
    output logic m_line_select,
    output logic m_line_level,
    output logic m_delay_after,
    output logic m_last_event
);

    localparam logic       LINE_SCL       = 1'b0;
    localparam logic       LINE_SDA       = 1'b1;
    localparam logic [2:0] PRE_START_FULL = 3'd0;
    localparam logic [2:0] PRE_START_PLAIN = 3'd2;
    localparam logic [2:0] PRE_START_END  = 3'd4;
    localparam logic [3:0] BIT_LAST       = 4'd8;
    localparam logic [1:0] PH_DATA        = 2'd0;
    localparam logic [1:0] PH_RISE        = 2'd1;
    localparam logic [1:0] PH_FALL        = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRE,
        ST_BITS
    } state_t;

    typedef struct packed {
        logic line;
        logic level;
        logic dly;
        logic last;
    } event_t;

    // Events that precede the data bits (or make up the whole command).
    function automatic event_t prefix_event(op_kind_t kind, logic [2:0] idx);
        event_t e;
        e = '0;
        unique case (kind)
            OP_INIT: begin
                if (idx == 3'd0) begin
                    e = '{LINE_SCL, 1'b1, 1'b0, 1'b0};
                end else begin
                    e = '{LINE_SDA, 1'b1, 1'b1, 1'b1};
                end
            end
            OP_STOP: begin
                case (idx)
                    3'd0:    e = '{LINE_SDA, 1'b0, 1'b1, 1'b0};
                    3'd1:    e = '{LINE_SCL, 1'b1, 1'b1, 1'b0};
                    default: e = '{LINE_SDA, 1'b1, 1'b1, 1'b1};
                endcase
            end
            OP_START: begin
                case (idx)
                    3'd0:    e = '{LINE_SDA, 1'b1, 1'b1, 1'b0};
                    3'd1:    e = '{LINE_SCL, 1'b1, 1'b1, 1'b0};
                    3'd2:    e = '{LINE_SDA, 1'b1, 1'b0, 1'b0};
                    3'd3:    e = '{LINE_SDA, 1'b0, 1'b1, 1'b0};
                    default: e = '{LINE_SCL, 1'b0, 1'b0, 1'b0};
                endcase
            end
            default: e = '0;
        endcase
        return e;
    endfunction

    state_t     state_reg, state_next;
    op_kind_t   kind_reg, kind_next;
    logic [7:0] shift_reg, shift_next;
    logic [2:0] pre_idx_reg, pre_idx_next;
    logic [3:0] bit_idx_reg, bit_idx_next;
    logic [1:0] phase_reg, phase_next;
    logic       m_valid_reg, m_valid_next;
    event_t     m_evt_reg, m_evt_next;

    event_t cur_evt;
    logic   out_free;
    logic   emit;
    logic   job_done;

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = (state_reg != ST_IDLE) && out_free;
    assign job_done  = emit && cur_evt.last;
    assign job_ready = (state_reg == ST_IDLE) || job_done;

    always_comb begin
        cur_evt = '0;
        unique case (state_reg)
            ST_PRE: cur_evt = prefix_event(kind_reg, pre_idx_reg);
            ST_BITS: begin
                case (phase_reg)
                    PH_DATA: cur_evt = '{LINE_SDA, shift_reg[7], 1'b0, 1'b0};
                    PH_RISE: cur_evt = '{LINE_SCL, 1'b1, 1'b0, 1'b0};
                    default: cur_evt = '{LINE_SCL, 1'b0, 1'b0, bit_idx_reg == BIT_LAST};
                endcase
            end
            default: cur_evt = '0;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        shift_next   = shift_reg;
        pre_idx_next = pre_idx_reg;
        bit_idx_next = bit_idx_reg;
        phase_next   = phase_reg;
        m_valid_next = m_valid_reg;
        m_evt_next   = m_evt_reg;

        if (out_free) begin
            m_valid_next = emit;
            if (emit) begin
                m_evt_next = cur_evt;
            end
        end

        if (emit) begin
            unique case (state_reg)
                ST_PRE: begin
                    if (cur_evt.last) begin
                        state_next = ST_IDLE;
                    end else if (kind_reg == OP_START && pre_idx_reg == PRE_START_END) begin
                        // Start condition done: the address byte follows.
                        state_next   = ST_BITS;
                        bit_idx_next = '0;
                        phase_next   = PH_DATA;
                    end else begin
                        pre_idx_next = pre_idx_reg + 3'd1;
                    end
                end
                ST_BITS: begin
                    if (phase_reg == PH_FALL) begin
                        // Zeros shift in, so the ninth bit goes out low.
                        shift_next   = {shift_reg[6:0], 1'b0};
                        bit_idx_next = bit_idx_reg + 4'd1;
                        phase_next   = PH_DATA;
                        if (cur_evt.last) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        phase_next = phase_reg + 2'd1;
                    end
                end
                default: state_next = state_reg;
            endcase
        end

        if (job_ready && job_valid) begin
            kind_next    = job.kind;
            shift_next   = job.byte_val;
            bit_idx_next = '0;
            phase_next   = PH_DATA;
            pre_idx_next = (job.kind == OP_START && !job.restart) ? PRE_START_PLAIN
                                                                  : PRE_START_FULL;
            state_next   = (job.kind == OP_SEND) ? ST_BITS : ST_PRE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        kind_reg    <= kind_next;
        shift_reg   <= shift_next;
        pre_idx_reg <= pre_idx_next;
        bit_idx_reg <= bit_idx_next;
        phase_reg   <= phase_next;
        m_evt_reg   <= m_evt_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_line_select = m_evt_reg.line;
    assign m_line_level  = m_evt_reg.level;
    assign m_delay_after = m_evt_reg.dly;
    assign m_last_event  = m_evt_reg.last;

    `I2CWO_ASSERT(a_back_bits_range, aclk, aresetn, state_reg != ST_BITS || (bit_idx_reg <= BIT_LAST && phase_reg <= PH_FALL), "bit counter out of range")
    `I2CWO_ASSERT(a_back_pre_range, aclk, aresetn, state_reg != ST_PRE || pre_idx_reg <= PRE_START_END, "prefix index out of range")
    `I2CWO_ASSERT_NEXT(a_back_done_idle, aclk, aresetn, job_done && !job_valid, state_reg == ST_IDLE && m_valid_reg && m_last_event, "command end not followed by idle")

endmodule

// ===== test/i2c_write_only_master_test.sv =====
// Self-checking testbench for the write-only I2C master: drives command beats, predicts
// the SCL/SDA line events of each command and compares every result beat in order.
// Depends on i2cwo_pkg and the i2c_write_only_master RTL.
`timescale 1ns / 1ps

module i2c_write_only_master_test;
    import i2cwo_pkg::*;

    localparam logic       LINE_SCL      = 1'b0;
    localparam logic       LINE_SDA      = 1'b1;
    localparam logic [2:0] CMD_RSVD_5    = 3'd5;
    localparam logic [2:0] CMD_RSVD_6    = 3'd6;
    localparam logic [2:0] CMD_RSVD_7    = 3'd7;
    localparam int         SETTLE_CYCLES = 10;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         RANDOM_ITEMS  = 70;

    typedef struct packed {
        logic sel;
        logic level;
        logic dly;
        logic last;
    } line_event_t;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       cfg_wr_en     = 1'b0;
    logic [6:0] cfg_wr_data   = '0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [2:0] s_cmd         = CMD_NOP;
    logic [7:0] s_data_byte   = '0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic       m_line_select;
    logic       m_line_level;
    logic       m_delay_after;
    logic       m_last_event;

    // Predictor state: a copy of the address register and the bus-started flag.
    logic [6:0]  model_addr        = '0;
    logic        model_bus_started = 1'b0;
    line_event_t expected_events[$];
    int          events_this_cmd;

    bit          idle_on          = 1'b1;
    int unsigned rx_hold_cycles   = 0;
    int          mismatches       = 0;
    int          commands_sent    = 0;
    int          events_checked   = 0;
    int          input_stalls     = 0;
    line_event_t front_event;

    i2c_write_only_master dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_line_select (m_line_select),
        .m_line_level  (m_line_level),
        .m_delay_after (m_delay_after),
        .m_last_event  (m_last_event)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void add_event(logic sel, logic level, logic dly);
        line_event_t ev;
        ev.sel   = sel;
        ev.level = level;
        ev.dly   = dly;
        ev.last  = 1'b0;
        expected_events.push_back(ev);
        events_this_cmd++;
    endfunction

    // Eight data bits MSB first, then a ninth bit with SDA held low.
    function automatic void add_byte_events(logic [7:0] b);
        for (int i = 7; i >= 0; i--) begin
            add_event(LINE_SDA, b[i], 1'b0);
            add_event(LINE_SCL, 1'b1, 1'b0);
            add_event(LINE_SCL, 1'b0, 1'b0);
        end
        add_event(LINE_SDA, 1'b0, 1'b0);
        add_event(LINE_SCL, 1'b1, 1'b0);
        add_event(LINE_SCL, 1'b0, 1'b0);
    endfunction

    function automatic void predict_line_events(logic [2:0] cmd, logic [7:0] data);
        line_event_t ev;
        events_this_cmd = 0;
        case (cmd)
            CMD_INIT: begin
                add_event(LINE_SCL, 1'b1, 1'b0);
                add_event(LINE_SDA, 1'b1, 1'b1);
            end
            CMD_START: begin
                if (model_bus_started) begin
                    add_event(LINE_SDA, 1'b1, 1'b1);
                    add_event(LINE_SCL, 1'b1, 1'b1);
                end
                add_event(LINE_SDA, 1'b1, 1'b0);
                add_event(LINE_SDA, 1'b0, 1'b1);
                add_event(LINE_SCL, 1'b0, 1'b0);
                model_bus_started = 1'b1;
                add_byte_events({model_addr, 1'b0});
            end
            CMD_SEND: add_byte_events(data);
            CMD_STOP: begin
                add_event(LINE_SDA, 1'b0, 1'b1);
                add_event(LINE_SCL, 1'b1, 1'b1);
                add_event(LINE_SDA, 1'b1, 1'b1);
                model_bus_started = 1'b0;
            end
            default: ;
        endcase
        if (events_this_cmd > 0) begin
            ev = expected_events.pop_back();
            ev.last = 1'b1;
            expected_events.push_back(ev);
        end
    endfunction

    // ---------------------------------------------------------------- checker

    task automatic check_field(string name, logic exp_val, logic act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, exp_val,
                     act_val);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected line event, expected none, actual sel=%0b lvl=%0b",
                         $time, m_line_select, m_line_level);
                mismatches++;
            end else begin
                front_event = expected_events.pop_front();
                check_field("line_select", front_event.sel, m_line_select);
                check_field("line_level", front_event.level, m_line_level);
                check_field("delay_after", front_event.dly, m_delay_after);
                check_field("last_event", front_event.last, m_last_event);
                events_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && !s_ready) begin
            input_stalls++;
        end
    end

    // ---------------------------------------------------------------- receiver

    initial begin
        int unsigned stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = idle_on ? $urandom_range(0, 6) : 0;
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // ---------------------------------------------------------------- sender

    task automatic send_command(logic [2:0] cmd, logic [7:0] data);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_data_byte <= data;
        do @(posedge aclk); while (!s_ready);
        predict_line_events(cmd, data);
        commands_sent++;
    endtask

    // No-op beats leave nothing to wait for, so a settle wait after the queue empties covers them.
    task automatic drain_events();
        s_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_address(logic [6:0] addr);
        drain_events();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= addr;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        model_addr = addr;
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed_commands();
        // Address still at its reset value of zero.
        send_command(CMD_START, 8'hC3);
        send_command(CMD_SEND, 8'h00);
        send_command(CMD_SEND, 8'hFF);
        send_command(CMD_SEND, 8'hA5);
        send_command(CMD_START, 8'h00);   // repeated start
        send_command(CMD_SEND, 8'h5A);
        send_command(CMD_INIT, 8'h3C);    // init leaves the bus marked started
        send_command(CMD_STOP, 8'hFF);
        send_command(CMD_STOP, 8'h00);    // stop while idle
        send_command(CMD_INIT, 8'h00);
        send_command(CMD_NOP, 8'hFF);
        send_command(CMD_RSVD_5, 8'hFF);
        send_command(CMD_RSVD_6, 8'h81);
        send_command(CMD_RSVD_7, 8'h7E);
        send_command(CMD_SEND, 8'h81);    // send with no start before it
        drain_events();
    endtask

    task automatic test_address_extremes();
        write_address(7'h7F);
        send_command(CMD_START, 8'h00);
        send_command(CMD_STOP, 8'h00);
        write_address(7'h55);
        send_command(CMD_START, 8'h00);
        send_command(CMD_START, 8'hFF);
        send_command(CMD_STOP, 8'h00);
        write_address(7'h2A);
        send_command(CMD_START, 8'h00);
        write_address(7'h00);
        send_command(CMD_START, 8'h00);   // restart with the new address
        send_command(CMD_STOP, 8'h00);
        drain_events();
    endtask

    // The receiver holds off long enough for the command queue to fill up.
    task automatic test_output_backpressure();
        idle_on = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
        send_command(CMD_START, 8'h00);
        for (int i = 0; i < 5; i++) begin
            send_command(CMD_SEND, 8'($urandom));
        end
        send_command(CMD_STOP, 8'h00);
        drain_events();
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int useful;
        int nbytes;
        logic [2:0] noise_cmd;
        useful = 0;
        for (int phase = 0; phase < 3; phase++) begin
            write_address(7'($urandom));
            idle_on = (phase != 1);
            while (useful < (phase + 1) * RANDOM_ITEMS / 3) begin
                if ($urandom_range(0, 9) < 8) begin
                    send_command(CMD_START, 8'($urandom));
                    nbytes = $urandom_range(1, 4);
                    for (int i = 0; i < nbytes; i++) begin
                        send_command(CMD_SEND, 8'($urandom));
                    end
                    useful += nbytes + 1;
                    if ($urandom_range(0, 2) == 0) begin
                        send_command(CMD_START, 8'($urandom));
                        send_command(CMD_SEND, 8'($urandom));
                        useful += 2;
                    end
                    // Now and then the stop is left out so the next start repeats.
                    if ($urandom_range(0, 4) != 0) begin
                        send_command(CMD_STOP, 8'($urandom));
                        useful++;
                    end
                end else begin
                    noise_cmd = 3'($urandom);
                    send_command(noise_cmd, 8'($urandom));
                    if (noise_cmd <= CMD_STOP) begin
                        useful++;
                    end
                end
            end
        end
        idle_on = 1'b1;
        drain_events();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_commands();
        test_address_extremes();
        test_output_backpressure();
        test_random_traffic();
        drain_events();
        $display("Run covered %0d command beats across all codes and several addresses,",
                 commands_sent);
        $display("with %0d line events checked and %0d cycles of input stall.",
                 events_checked, input_stalls);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("Timeout with %0d line events still expected.", expected_events.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/i2cwo_pkg.sv
rtl/i2cwo_fifo.sv
rtl/i2cwo_front.sv
rtl/i2cwo_back.sv
rtl/i2c_write_only_master.sv
test/i2c_write_only_master_test.sv
